// File: rtl/rgb_color_classifier_macros.svh
// ----------------------------------------------------------------------------
// rgb color classifier assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef RGB_COLOR_CLASSIFIER_MACROS_SVH
`define RGB_COLOR_CLASSIFIER_MACROS_SVH

// same-cycle implication, off during reset
`define RGBCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define RGBCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// what must hold right after a reset cycle
`define RGBCC_ASSERT_RESET(label, clk, rst_n, cons, msg) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rgbcc_pkg.sv
// ----------------------------------------------------------------------------
// rgbcc_pkg
// widths, class codes, stage flags and decision functions of the classifier
// ----------------------------------------------------------------------------
package rgbcc_pkg;

  localparam int CNT_W      = 16;
  localparam int CLS_W      = 3;
  localparam int RATIO_W    = 8;
  localparam int NUM_LANES  = 3;
  localparam int DIV_STEPS  = CNT_W;
  // input stage, one stage per quotient bit, output stage
  localparam int NUM_STAGES = DIV_STEPS + 2;

  localparam int LANE_R = 0;
  localparam int LANE_G = 1;
  localparam int LANE_B = 2;

  typedef enum logic [CLS_W-1:0] {
    CLS_BLACK  = 3'd0,
    CLS_RED    = 3'd1,
    CLS_GREEN  = 3'd2,
    CLS_BLUE   = 3'd3,
    CLS_YELLOW = 3'd4,
    CLS_WHITE  = 3'd5
  } cls_t;

  // compare results taken at the input stage
  typedef struct packed {
    logic low_rng;
    logic lt_br;
    logic le_rg;
    logic lt_gr;
    logic lt_bg;
    logic le_gb;
    logic lt_rb;
    logic lt_gb;
    logic sum_gt120;
    logic sum_gt220;
    logic sum_gt300;
    logic sum_gt400;
    logic sum_gt700;
    logic g2_gt_r3;
    logic g_gt_b2;
    logic r_gt_b2;
    logic r_gt400;
    logic g_gt580;
    logic b_gt320;
    logic g10_gt_r22;
    logic g10_gt_b22;
    logic g_lt_rb;
  } flags_t;

  // class decided early, or a request to use the quotient tree
  typedef struct packed {
    cls_t cls;
    logic use_ratio;
  } side_t;

  function automatic side_t classify_pre(flags_t f);
    side_t s;
    s.use_ratio = 1'b0;
    s.cls       = CLS_BLACK;
    priority if (f.low_rng) begin
      priority if (f.lt_br && f.le_rg) begin
        priority if (f.sum_gt300 && f.g2_gt_r3 && f.g_gt_b2) s.cls = CLS_GREEN;
        else if (f.g_gt_b2 && f.r_gt_b2 && f.sum_gt120)       s.cls = CLS_YELLOW;
        else if (f.r_gt400 && f.g_gt580 && f.b_gt320)         s.cls = CLS_WHITE;
        else                                                   s.cls = CLS_BLACK;
      end else if (f.lt_gr && f.lt_bg) begin
        s.cls = f.sum_gt220 ? CLS_RED : CLS_BLACK;
      end else if (f.le_gb && f.lt_rb) begin
        s.cls = CLS_BLUE;
      end else if (f.le_rg && !f.lt_br) begin
        priority if (!f.sum_gt400)                s.cls = CLS_BLACK;
        else if (f.g10_gt_r22 && f.g10_gt_b22)    s.cls = CLS_GREEN;
        else                                       s.cls = CLS_BLUE;
      end else if (f.g_lt_rb && f.sum_gt700) begin
        s.cls = CLS_WHITE;
      end else begin
        s.cls = CLS_BLACK;
      end
    end else if (f.lt_gb && f.lt_rb) begin
      s.cls = CLS_BLUE;
    end else if (f.lt_gr && f.lt_bg) begin
      s.cls = CLS_RED;
    end else begin
      s.use_ratio = 1'b1;
      s.cls       = CLS_WHITE;
    end
    return s;
  endfunction

  function automatic cls_t ratio_class(logic [RATIO_W-1:0] r, logic [RATIO_W-1:0] g,
                                       logic [RATIO_W-1:0] b);
    cls_t c;
    priority if (r >= 8'd9 && g <= 8'd4 && b <= 8'd1)   c = CLS_RED;
    else if (r > 8'd10 && g <= 8'd4 && b <= 8'd4)       c = CLS_RED;
    else if (r < 8'd3 && g <= 8'd4 && b < 8'd3)         c = CLS_BLACK;
    else if (r <= 8'd5 && g > 8'd10 && b < 8'd5)        c = CLS_GREEN;
    else if ((r < 8'd5 && g < 8'd5 && b > 8'd10) ||
             (r <= 8'd3 && g >= 8'd8 && b >= 8'd8))     c = CLS_BLUE;
    else if (r >= 8'd5 && g > 8'd6 && b >= 8'd7)        c = CLS_BLUE;
    else if (r <= 8'd4 && g >= 8'd10 && b >= 8'd6)      c = CLS_BLUE;
    else if (r <= 8'd8 && r >= 8'd6 && g >= 8'd6 && b < 8'd2) c = CLS_YELLOW;
    else if (r <= 8'd8 && b < 8'd2)                     c = CLS_RED;
    else if (r >= 8'd10 && g <= 8'd7 && b < 8'd2)       c = CLS_RED;
    else                                                c = CLS_WHITE;
    return c;
  endfunction

endpackage

// File: rtl/rgbcc_if.sv
// ----------------------------------------------------------------------------
// rgbcc channel interfaces
// valid/ready channels for the sample word and the class word
// ----------------------------------------------------------------------------
interface rgbcc_in_if import rgbcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] red_count;
  logic [CNT_W-1:0] green_count;
  logic [CNT_W-1:0] blue_count;
  logic [CNT_W-1:0] clear_count;

  modport source (
    output valid, red_count, green_count, blue_count, clear_count,
    input  ready
  );
  modport sink (
    input  valid, red_count, green_count, blue_count, clear_count,
    output ready
  );
endinterface

interface rgbcc_out_if import rgbcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CLS_W-1:0] color_class;

  modport source (output valid, color_class, input ready);
  modport sink (input valid, color_class, output ready);
endinterface

// File: rtl/rgbcc_div_pipe.sv
// ----------------------------------------------------------------------------
// rgbcc_div_pipe
// three-lane restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module rgbcc_div_pipe import rgbcc_pkg::*; (
  input  logic               clk,
  input  logic [DIV_STEPS-1:0] ld,
  input  logic [CNT_W-1:0]   dvd [NUM_LANES],
  input  logic [CNT_W-1:0]   dvs,
  output logic [RATIO_W-1:0] quo [NUM_LANES]
);

  logic [CNT_W-1:0]   rem_r [DIV_STEPS][NUM_LANES];
  logic [CNT_W-1:0]   dvd_r [DIV_STEPS][NUM_LANES];
  logic [RATIO_W-1:0] q_r   [DIV_STEPS][NUM_LANES];
  logic [CNT_W-1:0]   dvs_r [DIV_STEPS];

  logic [CNT_W-1:0]   rem_in [DIV_STEPS][NUM_LANES];
  logic [CNT_W-1:0]   dvd_in [DIV_STEPS][NUM_LANES];
  logic [RATIO_W-1:0] q_in   [DIV_STEPS][NUM_LANES];
  logic [CNT_W-1:0]   dvs_in [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign dvs_in[k] = dvs;
    end else begin : g_rest
      assign dvs_in[k] = dvs_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        dvs_r[k] <= dvs_in[k];
      end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [CNT_W:0]     trial;
      logic [CNT_W:0]     diff;
      logic               ge;
      logic [CNT_W-1:0]   rem_nxt;
      logic [CNT_W-1:0]   dvd_nxt;
      logic [RATIO_W-1:0] q_nxt;

      if (k == 0) begin : g_first
        assign rem_in[k][l] = '0;
        assign dvd_in[k][l] = dvd[l];
        assign q_in[k][l]   = '0;
      end else begin : g_rest
        assign rem_in[k][l] = rem_r[k-1][l];
        assign dvd_in[k][l] = dvd_r[k-1][l];
        assign q_in[k][l]   = q_r[k-1][l];
      end

      // zero divisor: every trial fits, so the quotient bits all come out one
      assign trial   = {rem_in[k][l], dvd_in[k][l][CNT_W-1]};
      assign diff    = trial - {1'b0, dvs_in[k]};
      assign ge      = trial >= {1'b0, dvs_in[k]};
      assign rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      assign dvd_nxt = {dvd_in[k][l][CNT_W-2:0], 1'b0};
      assign q_nxt   = {q_in[k][l][RATIO_W-2:0], ge};

      always_ff @(posedge clk) begin
        if (ld[k]) begin
          rem_r[k][l] <= rem_nxt;
          dvd_r[k][l] <= dvd_nxt;
          q_r[k][l]   <= q_nxt;
        end
      end
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_quo
    assign quo[l] = q_r[DIV_STEPS-1][l];
  end

endmodule

// File: rtl/rgb_color_classifier.sv
// ----------------------------------------------------------------------------
// rgb_color_classifier
// classifies one red/green/blue/clear sensor sample into a color class
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one sample word: red, green, blue and clear counts.
//   out_ch returns one class word per sample, in order: 0 black, 1 red,
//   2 green, 3 blue, 4 yellow, 5 white.
// timing
//   18 register stages: an input stage that takes all channel compares,
//   16 divider stages that each settle one quotient bit of count/clear in
//   three lanes, and an output register, passed by each sample in that order.
//   throughput is one word per cycle while out_ch.ready is high; the 16-step
//   divider sets the latency.
// stalls
//   each stage has its own valid bit and loads whenever its successor can
//   take its word, so bubbles close up and in_ch.ready stays high while any
//   stage is empty. with out_ch.ready low and the pipe full, in_ch.ready
//   drops and nothing is lost or repeated.
// reset
//   rst_n is synchronous; it clears all stage valid bits, data is left as is.
// ----------------------------------------------------------------------------
module rgb_color_classifier import rgbcc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  rgbcc_in_if.sink  in_ch,
  rgbcc_out_if.source out_ch
);

  // stage valid bits and the ready chain running back from the output
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_nxt;
  logic [NUM_STAGES:0]   rdy;

  assign rdy[NUM_STAGES] = out_ch.ready;

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_ctl
    assign rdy[i] = ~v_r[i] | rdy[i+1];
    if (i == 0) begin : g_head
      assign v_nxt[i] = rdy[i] ? in_ch.valid : v_r[i];
    end else begin : g_body
      assign v_nxt[i] = rdy[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready = rdy[0];

  // input stage: all threshold and cross-multiplied ratio compares
  flags_t           flags_nxt;
  flags_t           flags_s0_r;
  logic [CNT_W-1:0] dvd_s0_r [NUM_LANES];
  logic [CNT_W-1:0] clr_s0_r;

  always_comb begin
    logic [17:0] rx, gx, bx, sum;
    logic [20:0] rw, gw, bw;
    rx  = 18'(in_ch.red_count);
    gx  = 18'(in_ch.green_count);
    bx  = 18'(in_ch.blue_count);
    rw  = 21'(in_ch.red_count);
    gw  = 21'(in_ch.green_count);
    bw  = 21'(in_ch.blue_count);
    sum = rx + gx + bx;

    flags_nxt.low_rng    = (in_ch.red_count < 16'd1200) && (in_ch.green_count < 16'd1700) &&
                           (in_ch.blue_count < 16'd1200);
    flags_nxt.lt_br      = bx < rx;
    flags_nxt.le_rg      = rx <= gx;
    flags_nxt.lt_gr      = gx < rx;
    flags_nxt.lt_bg      = bx < gx;
    flags_nxt.le_gb      = gx <= bx;
    flags_nxt.lt_rb      = rx < bx;
    flags_nxt.lt_gb      = gx < bx;
    flags_nxt.sum_gt120  = sum > 18'd120;
    flags_nxt.sum_gt220  = sum > 18'd220;
    flags_nxt.sum_gt300  = sum > 18'd300;
    flags_nxt.sum_gt400  = sum > 18'd400;
    flags_nxt.sum_gt700  = sum > 18'd700;
    // green above 1.5 x red
    flags_nxt.g2_gt_r3   = (gx * 18'd2) > (rx * 18'd3);
    flags_nxt.g_gt_b2    = gx > (bx * 18'd2);
    flags_nxt.r_gt_b2    = rx > (bx * 18'd2);
    flags_nxt.r_gt400    = rx > 18'd400;
    flags_nxt.g_gt580    = gx > 18'd580;
    flags_nxt.b_gt320    = bx > 18'd320;
    // green above 2.2 x red and 2.2 x blue
    flags_nxt.g10_gt_r22 = (gw * 21'd10) > (rw * 21'd22);
    flags_nxt.g10_gt_b22 = (gw * 21'd10) > (bw * 21'd22);
    flags_nxt.g_lt_rb    = gx < (rx + bx);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      flags_s0_r       <= flags_nxt;
      dvd_s0_r[LANE_R] <= in_ch.red_count;
      dvd_s0_r[LANE_G] <= in_ch.green_count;
      dvd_s0_r[LANE_B] <= in_ch.blue_count;
      clr_s0_r         <= in_ch.clear_count;
    end
  end

  // quotient lanes; step k sits in stage k+1
  logic [RATIO_W-1:0] quo [NUM_LANES];

  rgbcc_div_pipe u_div (
    .clk (clk),
    .ld  (rdy[DIV_STEPS:1]),
    .dvd (dvd_s0_r),
    .dvs (clr_s0_r),
    .quo (quo)
  );

  // early decision resolved in stage 1, then carried alongside the divider
  side_t sb_r [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_side
    if (j == 0) begin : g_resolve
      always_ff @(posedge clk) begin
        if (rdy[1]) begin
          sb_r[j] <= classify_pre(flags_s0_r);
        end
      end
    end else begin : g_carry
      always_ff @(posedge clk) begin
        if (rdy[j+1]) begin
          sb_r[j] <= sb_r[j-1];
        end
      end
    end
  end

  // output stage: quotient range tree on the low 8 bits, or the early class
  cls_t cls_nxt;
  cls_t cls_r;

  assign cls_nxt = sb_r[DIV_STEPS-1].use_ratio ?
                   ratio_class(quo[LANE_R], quo[LANE_G], quo[LANE_B]) :
                   sb_r[DIV_STEPS-1].cls;

  always_ff @(posedge clk) begin
    if (rdy[NUM_STAGES-1]) begin
      cls_r <= cls_nxt;
    end
  end

  assign out_ch.valid       = v_r[NUM_STAGES-1];
  assign out_ch.color_class = cls_r;

endmodule

// File: rtl/rgbcc_checker.sv
// ----------------------------------------------------------------------------
// rgbcc_checker
// port-level checks of the classifier, bound to the top level
// ----------------------------------------------------------------------------
`include "rgb_color_classifier_macros.svh"

module rgbcc_checker import rgbcc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CLS_W-1:0] out_color_class
);

  `RGBCC_ASSERT_RESET(a_reset_empty, clk, rst_n, !out_valid, "output valid after reset")

  `RGBCC_ASSERT_SAME(a_cls_range, clk, rst_n, out_valid, out_color_class <= CLS_W'(CLS_WHITE), "class code out of range")

  // a free output stage means the pipe can take a word
  `RGBCC_ASSERT_SAME(a_no_block, clk, rst_n, !out_valid || out_ready, in_ready, "input blocked with output free")

  `RGBCC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_color_class), "stalled word changed")

endmodule

bind rgb_color_classifier rgbcc_checker u_rgbcc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_color_class (out_ch.color_class)
);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of rgb_color_classifier
// drives sensor sample words through a valid/ready channel and checks each
// class word, in order, against its hand-typed class or a behavioral classifier kept in the bench.
// a short table of hand-picked samples comes first, then random samples
// aimed at the low-reading tree, the quotient tree and the counter extremes,
// under four phases of sender idling and receiver stalling
// ----------------------------------------------------------------------------
module tb_top import rgbcc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // pipeline depth seen at the ports, plus margin for the drain at the end
  localparam int PIPE_LAT    = 17;
  localparam int TAIL_CYCLES = 3 * PIPE_LAT;
  // receiver hold-off, longer than the pipe so the input side backs up
  localparam int HOLD_CYCLES = 4 * NUM_STAGES;
  localparam int RAND_PER_PHASE = 262;
  localparam int NUM_DIRECTED   = 25;
  localparam int MAX_SHOWN      = 10;

  typedef struct {
    logic [CNT_W-1:0] r;
    logic [CNT_W-1:0] g;
    logic [CNT_W-1:0] b;
    logic [CNT_W-1:0] c;
  } sample_t;

  // directed row: a sample and, where obvious, its class typed in by hand
  typedef struct {
    sample_t s;
    bit      typed;
    cls_t    cls;
  } sample_row_t;

  logic clk;
  logic rst_n;

  rgbcc_in_if  in_if ();
  rgbcc_out_if out_if ();

  rgb_color_classifier u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // class words still owed by the block, oldest first
  cls_t pending_cls[$];

  int fail_count  = 0;
  int shown_count = 0;

  // idling percentages of the current phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // set by the sender to ask the receiver for one long hold-off
  bit hold_req = 1'b0;

  sample_row_t directed_rows [NUM_DIRECTED] = '{
    // all counts zero: low tree, dim green-on-top branch gives black
    '{'{16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, CLS_BLACK},
    // all counts at maximum: every quotient is one, black
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, CLS_BLACK},
    // bright dominant blue
    '{'{16'd0, 16'd0, 16'hFFFF, 16'd0}, 1'b1, CLS_BLUE},
    // bright red over green over blue
    '{'{16'hFFFF, 16'd1000, 16'd0, 16'd0}, 1'b1, CLS_RED},
    // zero clear count: all quotients 255, blue
    '{'{16'd2000, 16'd2000, 16'd2000, 16'd0}, 1'b1, CLS_BLUE},
    // quotient of 256 keeps only its low byte: zero, black
    '{'{16'd2560, 16'd2560, 16'd2560, 16'd10}, 1'b1, CLS_BLACK},
    // low tree, blue below red below green
    '{'{16'd200, 16'd400, 16'd50, 16'd1}, 1'b0, CLS_BLACK},
    '{'{16'd100, 16'd110, 16'd10, 16'd1}, 1'b0, CLS_BLACK},
    '{'{16'd410, 16'd590, 16'd330, 16'd1}, 1'b0, CLS_BLACK},
    '{'{16'd100, 16'd100, 16'd90, 16'd7}, 1'b0, CLS_BLACK},
    // low tree, red dominant, sum above and below the red limit
    '{'{16'd300, 16'd100, 16'd50, 16'd0}, 1'b0, CLS_BLACK},
    '{'{16'd100, 16'd50, 16'd10, 16'd0}, 1'b0, CLS_BLACK},
    // low tree, blue on top
    '{'{16'd10, 16'd20, 16'd30, 16'd0}, 1'b0, CLS_BLACK},
    // low tree, green on top: scaled ratio green, blue, and dim black
    '{'{16'd100, 16'd500, 16'd100, 16'd0}, 1'b0, CLS_BLACK},
    '{'{16'd200, 16'd300, 16'd200, 16'd0}, 1'b0, CLS_BLACK},
    '{'{16'd100, 16'd150, 16'd100, 16'd0}, 1'b0, CLS_BLACK},
    // low tree, last branch gives white
    '{'{16'd500, 16'd300, 16'd400, 16'd0}, 1'b0, CLS_BLACK},
    // edges of the low range
    '{'{16'd1199, 16'd1699, 16'd1199, 16'hFFFF}, 1'b0, CLS_BLACK},
    '{'{16'd1200, 16'd1200, 16'd1200, 16'd100}, 1'b0, CLS_BLACK},
    // quotient tree: yellow, red with low blue, green, white, second red rule
    '{'{16'd7000, 16'd7000, 16'd1000, 16'd1000}, 1'b0, CLS_BLACK},
    '{'{16'd4000, 16'd4000, 16'd1000, 16'd1000}, 1'b0, CLS_BLACK},
    '{'{16'd3000, 16'd12000, 16'd2000, 16'd1000}, 1'b0, CLS_BLACK},
    '{'{16'd12000, 16'd12000, 16'd5000, 16'd1000}, 1'b0, CLS_BLACK},
    '{'{16'd11000, 16'd4000, 16'd4000, 16'd1000}, 1'b0, CLS_BLACK},
    // quotient of 65535 by one wraps to 255
    '{'{16'hFFFF, 16'd0, 16'hFFFF, 16'd1}, 1'b0, CLS_BLACK}
  };

  // behavioral classifier: low readings by the compare tree, bright ones
  // by order tests, then by the 8-bit quotients over the clear count
  function automatic cls_t sample_class(sample_t s);
    int unsigned r, g, b, c, sum;
    int unsigned qr, qg, qb;
    r = 32'(s.r);
    g = 32'(s.g);
    b = 32'(s.b);
    c = 32'(s.c);
    sum = r + g + b;
    if (r < 1200 && g < 1700 && b < 1200) begin
      if (b < r && r <= g) begin
        if (sum > 300 && 2 * g > 3 * r && g > 2 * b) return CLS_GREEN;
        if (g > 2 * b && r > 2 * b && sum > 120) return CLS_YELLOW;
        if (r > 400 && g > 580 && b > 320) return CLS_WHITE;
        return CLS_BLACK;
      end
      if (g < r && b < g) return (sum > 220) ? CLS_RED : CLS_BLACK;
      if (g <= b && r < b) return CLS_BLUE;
      if (r <= g && b >= r) begin
        if (sum <= 400) return CLS_BLACK;
        // factor 2.2 as an exact cross-multiplication
        if (10 * g > 22 * r && 10 * g > 22 * b) return CLS_GREEN;
        return CLS_BLUE;
      end
      if (g < r + b && sum > 700) return CLS_WHITE;
      return CLS_BLACK;
    end
    if (b > g && b > r) return CLS_BLUE;
    if (r > g && g > b) return CLS_RED;
    // zero clear means every quotient is 255
    qr = (c == 0) ? 255 : (r / c) & 8'hFF;
    qg = (c == 0) ? 255 : (g / c) & 8'hFF;
    qb = (c == 0) ? 255 : (b / c) & 8'hFF;
    if (qr >= 9 && qg <= 4 && qb <= 1) return CLS_RED;
    if (qr > 10 && qg <= 4 && qb <= 4) return CLS_RED;
    if (qr < 3 && qg <= 4 && qb < 3) return CLS_BLACK;
    if (qr <= 5 && qg > 10 && qb < 5) return CLS_GREEN;
    if ((qr < 5 && qg < 5 && qb > 10) || (qr <= 3 && qg >= 8 && qb >= 8))
      return CLS_BLUE;
    if (qr >= 5 && qg > 6 && qb >= 7) return CLS_BLUE;
    if (qr <= 4 && qg >= 10 && qb >= 6) return CLS_BLUE;
    if (qr <= 8 && qr >= 6 && qg >= 6 && qb < 2) return CLS_YELLOW;
    if (qr <= 8 && qb < 2) return CLS_RED;
    if (qr >= 10 && qg <= 7 && qb < 2) return CLS_RED;
    return CLS_WHITE;
  endfunction

  // one count built as quotient * clear plus a remainder, clipped to 16 bits
  function automatic logic [CNT_W-1:0] count_for_quotient(int unsigned q,
                                                          int unsigned c);
    int unsigned v;
    v = q * c + $urandom_range(0, c - 1);
    return (v > 65535) ? 16'hFFFF : v[CNT_W-1:0];
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int unsigned pick;
    int unsigned c;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // low readings, often dim so the sum limits matter
      if ($urandom_range(0, 2) == 0) begin
        s.r = 16'($urandom_range(0, 400));
        s.g = 16'($urandom_range(0, 500));
        s.b = 16'($urandom_range(0, 400));
      end else begin
        s.r = 16'($urandom_range(0, 1199));
        s.g = 16'($urandom_range(0, 1699));
        s.b = 16'($urandom_range(0, 1199));
      end
      s.c = 16'($urandom);
    end else if (pick < 75) begin
      // bright readings aimed at small quotients of the ratio tree
      c = $urandom_range(100, 5000);
      s.c = 16'(c);
      s.r = count_for_quotient($urandom_range(0, 16), c);
      s.g = count_for_quotient($urandom_range(0, 16), c);
      s.b = count_for_quotient($urandom_range(0, 16), c);
    end else if (pick < 85) begin
      // tiny or zero clear: quotient wrap and the 255 case
      s.r = 16'($urandom_range(1200, 65535));
      s.g = 16'($urandom_range(0, 65535));
      s.b = 16'($urandom_range(0, 65535));
      s.c = 16'($urandom_range(0, 3));
    end else if (pick < 92) begin
      // around the low-range limits
      s.r = 16'($urandom_range(1150, 1250));
      s.g = 16'($urandom_range(1650, 1750));
      s.b = 16'($urandom_range(1150, 1250));
      s.c = 16'($urandom_range(0, 300));
    end else begin
      s.r = 16'($urandom);
      s.g = 16'($urandom);
      s.b = 16'($urandom);
      s.c = 16'($urandom);
    end
    return s;
  endfunction

  // offer one word, waiting out idle gaps and back-pressure; called at a
  // falling edge and returns at the falling edge after acceptance
  task automatic offer_sample(sample_t s, bit typed, cls_t typed_cls);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.red_count   <= s.r;
    in_if.green_count <= s.g;
    in_if.blue_count  <= s.b;
    in_if.clear_count <= s.c;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_cls.push_back(typed ? typed_cls : sample_class(s));
    @(negedge clk);
  endtask

  task automatic flag_error(string what, int unsigned want, int unsigned got);
    fail_count++;
    if (shown_count < MAX_SHOWN) begin
      shown_count++;
      $display("%0t: %s expected %0d actual %0d", $realtime, what, want, got);
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the pipe hangs
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls per phase, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // result checker: every accepted class word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_cls.size() == 0) begin
        flag_error("unexpected class word", 0, 32'(out_if.color_class));
      end else if (out_if.color_class !== pending_cls[0]) begin
        flag_error("class mismatch", 32'(pending_cls[0]), 32'(out_if.color_class));
        void'(pending_cls.pop_front());
      end else begin
        void'(pending_cls.pop_front());
      end
    end
  end

  // sender and run control
  initial begin : sender
    int phase;
    int drain;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.red_count   = '0;
    in_if.green_count = '0;
    in_if.blue_count  = '0;
    in_if.clear_count = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, no idling
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].cls);
    end

    // random words under four idling phases
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 47;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 47;
          // long hold-off while words keep coming, so the pipe fills
          hold_req = 1'b1;
        end
        default: begin
          send_idle_pct = 36;
          recv_stall_pct = 36;
        end
      endcase
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        offer_sample(random_sample(), 1'b0, CLS_BLACK);
      end
    end
    in_if.valid <= 1'b0;

    // drain: wait for the owed words, then watch for strays
    while (pending_cls.size() != 0) @(posedge clk);
    for (drain = 0; drain < TAIL_CYCLES; drain++) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
